[rtl/online_lp_dual_price_update_assert.svh]
// Assertion macros for the online LP dual price update block.
// Include this file inside a module that has clk and arst_n.
`ifndef ONLINE_LP_DUAL_PRICE_UPDATE_ASSERT_SVH
`define ONLINE_LP_DUAL_PRICE_UPDATE_ASSERT_SVH

// Holds at every clock edge outside reset.
`define OLP_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define OLP_ASSERT_IMP(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define OLP_ASSERT_NXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`endif

[rtl/olp_pkg.sv]
// Package for the online LP dual price update block: constants, row word type
// and fixed-point helper functions. Depends on nothing.
`default_nettype none
package olp_pkg;

	localparam int NUM_ROWS        = 1024;
	localparam int NUM_COLS        = 4096;
	localparam int MAX_COL_ENTRIES = 64;
	localparam int ROW_AW          = 10;
	localparam int COL_AW          = 12;
	localparam int BUF_AW          = 6;
	localparam int ECNT_W          = 7;
	localparam int BUF_W           = 42;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_ENTRY = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic       KIND_DECISION = 1'b0;
	localparam logic       KIND_PRICE    = 1'b1;

	localparam logic       CFG_STEP_SIZE = 1'b0;
	localparam logic       CFG_SENSE     = 1'b1;

	localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
	localparam logic [62:0] MAG_LIMIT = 63'h4000_0000_0000_0000;

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] rate;
		logic        eq;
		logic [31:0] stamp;
	} row_word_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) r = 32'h7fff_ffff;
		else if (v < -64'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] clamp_row(input logic [31:0] p, input logic eq);
		return (!eq && p[31]) ? 32'h0 : p;
	endfunction

endpackage
`default_nettype wire

[rtl/olp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module olp_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/online_lp_dual_price_update.sv]
// Top level of the online LP dual price update block: sequencer, arithmetic
// and the row, entry buffer and take count memories. Uses olp_pkg and olp_ram.
//
// Channel  Direction  Handshake                      Payload
// s_axis   in         s_axis_tvalid / s_axis_tready  tuser mode, tlast last_entry, tdata
// m_axis   out        m_axis_tvalid / m_axis_tready  tuser kind, tdata
// cfg      in         cfg_we (no wait)               cfg_index, cfg_data
//
// Load and clear words are done in the idle state; a price read waits in RDP on any
// output stall. A column entry with a nonzero runs through states D1 to D6, set by
// the row memory read-modify-write and the decay multiply split into two partial
// products. A last entry runs DC0, DC1, the walk states W0 to W3 per buffered nonzero
// for a taken column, and FIN. After reset a clearing pass zeroes the take count
// memory; no input word is accepted during it. A waiting result holds the block
// before the next word is taken only when a new result has to be written.
`default_nettype none
module online_lp_dual_price_update (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata fields from bit 0: row_index[9:0], column_index[21:10], coefficient[53:22],
	// rate[85:54], row_is_equality[86], has_entry[87], objective[119:88]
	input  wire logic [119:0] s_axis_tdata,
	// tuser fields from bit 0: mode[1:0]
	input  wire logic [1:0]   s_axis_tuser,
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata fields from bit 0: out_column[11:0], take[12], column_count[28:13],
	// out_row[38:29], price[70:39], zero pad[71]
	output logic      [71:0]  m_axis_tdata,
	// tuser fields from bit 0: kind[0]
	output logic              m_axis_tuser,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [16:0]  cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDP  = 4'd1;
	localparam logic [3:0] S_D1   = 4'd2;
	localparam logic [3:0] S_D2   = 4'd3;
	localparam logic [3:0] S_D3   = 4'd4;
	localparam logic [3:0] S_D4   = 4'd5;
	localparam logic [3:0] S_D5   = 4'd6;
	localparam logic [3:0] S_D6   = 4'd7;
	localparam logic [3:0] S_DC0  = 4'd8;
	localparam logic [3:0] S_DC1  = 4'd9;
	localparam logic [3:0] S_W0   = 4'd10;
	localparam logic [3:0] S_W1   = 4'd11;
	localparam logic [3:0] S_W2   = 4'd12;
	localparam logic [3:0] S_W3   = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;

	logic [3:0] state_q;

	// Configuration registers.
	logic [16:0] step_q;
	logic        sense_q;

	// Captured input word.
	logic [olp_pkg::ROW_AW-1:0]      row_q;
	logic [olp_pkg::COL_AW-1:0]      col_q;
	logic [31:0]                     coef_q;
	logic                            last_q;
	logic [31:0]                     obj_q;

	// Column state.
	logic [31:0]                     uc_q;
	logic [olp_pkg::ECNT_W-1:0]      entry_cnt_q;
	logic [olp_pkg::ECNT_W-1:0]      walk_k_q;
	logic [63:0]                     dot_q;
	logic                            take_q;
	logic [15:0]                     tc_q;

	// Row fields held over a read-modify-write.
	logic [31:0]                     price_q;
	logic [31:0]                     rate_q;
	logic                            eq_q;
	logic [31:0]                     newp_q;
	logic                            wneg_q;

	// Pipeline of the decay multiply.
	logic [48:0]                     m_s1;
	logic [31:0]                     e_s1;
	logic [56:0]                     plo_s2;
	logic [55:0]                     phi_s3;
	logic [63:0]                     prod_s5;
	logic [49:0]                     rmag_s3;

	// Clearing pass over the take count memory.
	logic                            clr_busy_q;
	logic [olp_pkg::COL_AW-1:0]      clr_addr_q;

	// Output register.
	logic                            ov_q;
	logic                            okind_q;
	logic [olp_pkg::COL_AW-1:0]      ocol_q;
	logic                            otake_q;
	logic [15:0]                     ocnt_q;
	logic [olp_pkg::ROW_AW-1:0]      orow_q;
	logic [31:0]                     oprice_q;

	// Input fields.
	logic [olp_pkg::ROW_AW-1:0] in_row;
	logic [olp_pkg::COL_AW-1:0] in_col;
	logic [31:0]                in_coef;
	logic [31:0]                in_rate;
	logic                       in_eq;
	logic                       in_has;
	logic [31:0]                in_obj;
	logic                       in_acc;
	logic                       out_free;
	logic                       out_load;

	assign in_row  = s_axis_tdata[9:0];
	assign in_col  = s_axis_tdata[21:10];
	assign in_coef = s_axis_tdata[53:22];
	assign in_rate = s_axis_tdata[85:54];
	assign in_eq   = s_axis_tdata[86];
	assign in_has  = s_axis_tdata[87];
	assign in_obj  = s_axis_tdata[119:88];

	assign s_axis_tready = (state_q == S_IDLE) && !clr_busy_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !ov_q || m_axis_tready;
	// A result word is loaded into the output register in this cycle.
	assign out_load      = ((state_q == S_RDP) || (state_q == S_FIN)) && out_free;

	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser  = okind_q;
	assign m_axis_tdata  = {1'b0, oprice_q, orow_q, ocnt_q, otake_q, ocol_q};

	// Row memory: price, rate, type and stamp in one word.
	olp_pkg::row_word_t         row_wdata, row_rdata;
	logic                       row_we, row_re;
	logic [olp_pkg::ROW_AW-1:0] row_waddr, row_raddr;

	olp_ram #(.Width($bits(olp_pkg::row_word_t)), .Depth(olp_pkg::NUM_ROWS)) u_row_ram (
		.clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
		.re(row_re), .raddr(row_raddr), .rdata(row_rdata)
	);

	// Entry buffer: row index in the upper bits, coefficient in the lower.
	logic                       buf_we;
	logic [olp_pkg::BUF_W-1:0]  buf_rdata;

	olp_ram #(.Width(olp_pkg::BUF_W), .Depth(olp_pkg::MAX_COL_ENTRIES)) u_buf_ram (
		.clk(clk), .we(buf_we), .waddr(entry_cnt_q[olp_pkg::BUF_AW-1:0]),
		.wdata({row_q, coef_q}), .re(state_q == S_W0),
		.raddr(walk_k_q[olp_pkg::BUF_AW-1:0]), .rdata(buf_rdata)
	);

	// Take count memory.
	logic                       tc_we;
	logic [olp_pkg::COL_AW-1:0] tc_waddr;
	logic [15:0]                tc_wdata, tc_rdata, tc_new;

	olp_ram #(.Width(16), .Depth(olp_pkg::NUM_COLS)) u_tc_ram (
		.clk(clk), .we(tc_we), .waddr(tc_waddr), .wdata(tc_wdata),
		.re(state_q == S_DC0), .raddr(col_q), .rdata(tc_rdata)
	);

	assign tc_new = (take_q && tc_q != 16'hffff) ? tc_q + 16'd1 : tc_q;

	// Arithmetic.
	logic [31:0]        rd_ratemag;
	logic [80:0]        dec_full;
	logic [62:0]        dec_mag;
	logic [46:0]        dec_r;
	logic signed [63:0] dec_delta;
	logic [31:0]        dec_newp;
	logic signed [32:0] w_diff;
	logic [32:0]        w_dmag;
	logic [33:0]        w_r;
	logic signed [63:0] w_delta;
	logic [31:0]        w_newp;
	logic [64:0]        dot_sum65;
	logic [63:0]        dot_next;
	logic signed [63:0] obj_lhs;

	always_comb begin
		rd_ratemag = row_rdata.rate[31] ? (32'd0 - row_rdata.rate) : row_rdata.rate;

		// Elapsed decay: step * |rate| * elapsed, saturated at 2^62.
		dec_full  = (81'(phi_s3) << 25) + 81'(plo_s2);
		dec_mag   = (dec_full > 81'(olp_pkg::MAG_LIMIT)) ? olp_pkg::MAG_LIMIT : dec_full[62:0];
		dec_r     = 47'((64'(dec_mag) + 64'd32768) >> 16);
		dec_delta = rate_q[31] ? -$signed(64'(dec_r)) : $signed(64'(dec_r));
		dec_newp  = olp_pkg::clamp_row(
			olp_pkg::sat32($signed({{32{price_q[31]}}, price_q}) - dec_delta), eq_q);

		// Raise by step * (coefficient - rate).
		w_diff  = $signed({coef_q[31], coef_q}) - $signed({row_rdata.rate[31], row_rdata.rate});
		w_dmag  = w_diff[32] ? (33'd0 - 33'(w_diff)) : 33'(w_diff);
		w_r     = 34'((51'(rmag_s3) + 51'd32768) >> 16);
		w_delta = wneg_q ? -$signed(64'(w_r)) : $signed(64'(w_r));
		w_newp  = olp_pkg::clamp_row(
			olp_pkg::sat32($signed({{32{price_q[31]}}, price_q}) + w_delta), eq_q);

		// Saturating accumulation of the dot product.
		dot_sum65 = {dot_q[63], dot_q} + {prod_s5[63], prod_s5};
		if (dot_sum65[64] != dot_sum65[63]) begin
			dot_next = dot_sum65[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		end else begin
			dot_next = dot_sum65[63:0];
		end

		obj_lhs = $signed({{16{obj_q[31]}}, obj_q, 16'h0});
	end

	// Memory port selection.
	always_comb begin
		row_we    = 1'b0;
		row_waddr = row_q;
		row_wdata = '{price: newp_q, rate: rate_q, eq: eq_q, stamp: uc_q};
		row_re    = 1'b0;
		row_raddr = in_row;
		buf_we    = 1'b0;
		tc_we     = 1'b0;
		tc_waddr  = col_q;
		tc_wdata  = tc_new;
		case (state_q)
			S_IDLE: begin
				if (clr_busy_q) begin
					tc_we    = 1'b1;
					tc_waddr = clr_addr_q;
					tc_wdata = 16'h0;
				end else if (in_acc) begin
					case (s_axis_tuser)
						olp_pkg::MODE_LOAD: begin
							row_we    = 1'b1;
							row_waddr = in_row;
							row_wdata = '{price: (sense_q ? 32'h0 : olp_pkg::ONE_Q16),
								rate: in_rate, eq: in_eq, stamp: 32'h0};
						end
						olp_pkg::MODE_CLEAR: begin
							tc_we    = 1'b1;
							tc_waddr = in_col;
							tc_wdata = 16'h0;
						end
						olp_pkg::MODE_READ: row_re = 1'b1;
						olp_pkg::MODE_ENTRY: row_re = in_has;
						default: row_re = 1'b0;
					endcase
				end
			end
			S_D5: begin
				row_we = 1'b1;
				buf_we = entry_cnt_q < olp_pkg::ECNT_W'(olp_pkg::MAX_COL_ENTRIES);
			end
			S_W1: begin
				row_re    = 1'b1;
				row_raddr = buf_rdata[olp_pkg::BUF_W-1:32];
			end
			S_W3: begin
				row_we    = 1'b1;
				row_wdata = '{price: w_newp, rate: rate_q, eq: eq_q, stamp: uc_q};
			end
			S_FIN: tc_we = out_free;
			default: row_we = 1'b0;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= 17'd0;
			sense_q     <= 1'b1;
			uc_q        <= 32'd0;
			entry_cnt_q <= '0;
			walk_k_q    <= '0;
			dot_q       <= 64'd0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			ov_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == olp_pkg::CFG_STEP_SIZE) step_q <= cfg_data;
				else sense_q <= cfg_data[0];
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == olp_pkg::COL_AW'(olp_pkg::NUM_COLS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (s_axis_tuser)
							olp_pkg::MODE_LOAD: uc_q <= 32'd0;
							olp_pkg::MODE_READ: state_q <= S_RDP;
							olp_pkg::MODE_ENTRY: begin
								if (in_has) state_q <= S_D1;
								else if (s_axis_tlast) state_q <= S_DC0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RDP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_D1: state_q <= S_D2;
				S_D2: state_q <= S_D3;
				S_D3: state_q <= S_D4;
				S_D4: state_q <= S_D5;
				S_D5: begin
					if (entry_cnt_q < olp_pkg::ECNT_W'(olp_pkg::MAX_COL_ENTRIES)) begin
						entry_cnt_q <= entry_cnt_q + 1'b1;
					end
					state_q <= S_D6;
				end
				S_D6: begin
					dot_q   <= dot_next;
					state_q <= last_q ? S_DC0 : S_IDLE;
				end
				S_DC0: begin
					uc_q    <= uc_q + 32'd1;
					state_q <= S_DC1;
				end
				S_DC1: begin
					walk_k_q <= '0;
					state_q  <= (take_q && entry_cnt_q != '0) ? S_W0 : S_FIN;
				end
				S_W0: state_q <= S_W1;
				S_W1: state_q <= S_W2;
				S_W2: state_q <= S_W3;
				S_W3: begin
					walk_k_q <= walk_k_q + 1'b1;
					state_q  <= (walk_k_q + 1'b1 < entry_cnt_q) ? S_W0 : S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						entry_cnt_q <= '0;
						dot_q       <= 64'd0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q  <= in_row;
			col_q  <= in_col;
			coef_q <= in_coef;
			last_q <= s_axis_tlast;
			obj_q  <= in_obj;
		end
		case (state_q)
			S_RDP: begin
				if (out_free) begin
					okind_q  <= olp_pkg::KIND_PRICE;
					ocol_q   <= '0;
					otake_q  <= 1'b0;
					ocnt_q   <= 16'd0;
					orow_q   <= row_q;
					oprice_q <= row_rdata.price;
				end
			end
			S_D1: begin
				price_q <= row_rdata.price;
				rate_q  <= row_rdata.rate;
				eq_q    <= row_rdata.eq;
				m_s1    <= 49'(step_q) * 49'(rd_ratemag);
				e_s1    <= uc_q - row_rdata.stamp;
			end
			S_D2: plo_s2 <= 57'(m_s1[24:0]) * 57'(e_s1);
			S_D3: phi_s3 <= 56'(m_s1[48:25]) * 56'(e_s1);
			S_D4: newp_q <= dec_newp;
			S_D5: prod_s5 <= $signed(64'(signed'(coef_q))) * $signed(64'(signed'(newp_q)));
			S_DC0: take_q <= obj_lhs >= $signed(dot_q);
			S_DC1: tc_q <= tc_rdata;
			S_W1: begin
				coef_q <= buf_rdata[31:0];
				row_q  <= buf_rdata[olp_pkg::BUF_W-1:32];
			end
			S_W2: begin
				price_q <= row_rdata.price;
				eq_q    <= row_rdata.eq;
				rate_q  <= row_rdata.rate;
				// Sign of the difference is held for the raise in the next cycle.
				wneg_q  <= w_diff[32];
				rmag_s3 <= 50'(step_q) * 50'(w_dmag);
			end
			S_W3: rate_q <= rate_q;
			S_FIN: begin
				if (out_free) begin
					okind_q  <= olp_pkg::KIND_DECISION;
					ocol_q   <= col_q;
					otake_q  <= take_q;
					ocnt_q   <= tc_new;
					orow_q   <= '0;
					oprice_q <= 32'h0;
				end
			end
			default: ;
		endcase
	end

	`include "online_lp_dual_price_update_assert.svh"

	`OLP_ASSERT_NOW(a_entry_bound, entry_cnt_q <= olp_pkg::ECNT_W'(olp_pkg::MAX_COL_ENTRIES), "entry count beyond buffer depth")
	`OLP_ASSERT_IMP(a_walk_range, state_q == S_W0, walk_k_q < entry_cnt_q, "walk index beyond buffered entries")
	`OLP_ASSERT_NXT(a_counter_step, state_q == S_DC0, uc_q == $past(uc_q) + 32'd1, "update counter did not advance")
	`OLP_ASSERT_IMP(a_clear_blocks, clr_busy_q, !s_axis_tready && !ov_q, "word accepted during clearing pass")

endmodule
`default_nettype wire
